// ----- rtl/crec_pkg.sv -----
package crec_pkg;

  // Width of the cluster numbers that take part in the run compare.
  localparam int unsigned ClusterBits = 32;

  // Fixed field widths of the ports.
  localparam int unsigned ClusterW    = 32;
  localparam int unsigned BlockSizeW  = 26;
  localparam int unsigned RootOffsetW = 48;
  localparam int unsigned CfgDataW    = 48;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned CountW      = 32;
  localparam int unsigned ExtW        = 64;

  localparam int unsigned StartProdW = ClusterBits + BlockSizeW;
  localparam int unsigned LenProdW   = CountW + BlockSizeW;

  localparam logic [BlockSizeW-1:0] BlockSizeReset = BlockSizeW'(512);

  // Queue depths between and behind the two halves.
  localparam int unsigned RecQDepth = 4;
  localparam int unsigned OutQDepth = 4;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BLOCK_SIZE  = 1'b0,
    CFG_ROOT_OFFSET = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    SEQ_FIRST,
    SEQ_SECOND
  } seq_e;

  typedef struct packed {
    logic [ClusterBits-1:0] start;
    logic [CountW-1:0]      count;
  } run_t;

  // Everything one input item leaves for the back end: an optional run closed by a
  // break, and an optional run closed by the end of the list.
  typedef struct packed {
    logic brk_vld;
    run_t brk_run;
    logic brk_last;
    logic end_vld;
    run_t end_run;
  } step_rec_t;

  typedef struct packed {
    run_t run;
    logic closes;
    logic last;
  } emit_t;

  typedef struct packed {
    logic [ExtW-1:0] offset;
    logic [ExtW-1:0] length;
    logic            closes;
    logic            last;
  } result_t;

endpackage

// ----- rtl/crec_front.sv -----
module crec_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            acc_i,
  input  logic [crec_pkg::ClusterBits-1:0] cluster_i,
  input  logic                            list_end_i,
  output logic                            rec_vld_o,
  output crec_pkg::step_rec_t             rec_o
);

  logic                             run_open_q, run_open_d;
  logic [crec_pkg::ClusterBits-1:0] start_q, start_d;
  logic [crec_pkg::CountW-1:0]      count_q, count_d;
  logic [crec_pkg::ClusterBits-1:0] prev_q, prev_d;
  logic [crec_pkg::ClusterBits-1:0] diff;

  assign diff = cluster_i - prev_q;

  always_comb begin
    run_open_d = run_open_q;
    start_d    = start_q;
    count_d    = count_q;
    prev_d     = prev_q;
    rec_vld_o  = 1'b0;
    rec_o      = '0;
    if (acc_i) begin
      prev_d = cluster_i;
      if (!run_open_q) begin
        start_d = cluster_i;
        count_d = crec_pkg::CountW'(1);
      end else if (diff == crec_pkg::ClusterBits'(1)) begin
        if (count_q != '1) begin
          count_d = count_q + crec_pkg::CountW'(1);
        end
      end else begin
        rec_o.brk_vld       = 1'b1;
        rec_o.brk_run.start = start_q;
        rec_o.brk_run.count = count_q;
        start_d             = cluster_i;
        count_d             = crec_pkg::CountW'(1);
      end
      rec_o.brk_last = !list_end_i;
      if (list_end_i) begin
        rec_o.end_vld       = 1'b1;
        rec_o.end_run.start = start_d;
        rec_o.end_run.count = count_d;
        run_open_d          = 1'b0;
      end else begin
        run_open_d = 1'b1;
      end
      rec_vld_o = rec_o.brk_vld | rec_o.end_vld;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_open_q <= 1'b0;
      start_q    <= '0;
      count_q    <= '0;
      prev_q     <= '0;
    end else begin
      run_open_q <= run_open_d;
      start_q    <= start_d;
      count_q    <= count_d;
      prev_q     <= prev_d;
    end
  end

endmodule

// ----- rtl/crec_rec_fifo.sv -----
module crec_rec_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  crec_pkg::step_rec_t data_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                empty_o,
  output crec_pkg::step_rec_t data_o
);

  localparam int unsigned PtrW = $clog2(crec_pkg::RecQDepth);
  localparam int unsigned CntW = $clog2(crec_pkg::RecQDepth + 1);

  crec_pkg::step_rec_t mem_q [crec_pkg::RecQDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(crec_pkg::RecQDepth));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(crec_pkg::RecQDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(crec_pkg::RecQDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- rtl/crec_back.sv -----
module crec_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             rec_empty_i,
  input  crec_pkg::step_rec_t              rec_i,
  output logic                             rec_pop_o,
  input  logic [crec_pkg::BlockSizeW-1:0]  block_size_i,
  input  logic [crec_pkg::ExtW-1:0]        base_i,
  input  logic                             pop_i,
  output logic                             empty_o,
  output crec_pkg::result_t                res_o
);

  localparam int unsigned PtrW = $clog2(crec_pkg::OutQDepth);
  localparam int unsigned CntW = $clog2(crec_pkg::OutQDepth + 1);

  crec_pkg::seq_e  seq_q, seq_d;
  crec_pkg::emit_t iss;
  logic            issue, en, oq_full;

  logic                            s1_vld_q;
  logic [crec_pkg::StartProdW-1:0] s1_pstart_q;
  logic [crec_pkg::LenProdW-1:0]   s1_plen_q;
  logic                            s1_closes_q, s1_last_q;
  logic                            s2_vld_q;
  crec_pkg::result_t               s2_q;

  crec_pkg::result_t oq_mem_q [crec_pkg::OutQDepth];
  logic [PtrW-1:0]   oq_wr_q, oq_rd_q;
  logic [CntW-1:0]   oq_cnt_q, oq_cnt_d;
  logic              oq_push, oq_pop;

  // The whole pipeline moves together while the output queue has room.
  assign oq_full = (oq_cnt_q == CntW'(crec_pkg::OutQDepth));
  assign en      = !oq_full;

  always_comb begin
    seq_d = seq_q;
    if (en && !rec_empty_i) begin
      unique case (seq_q)
        crec_pkg::SEQ_FIRST: begin
          if (rec_i.brk_vld && rec_i.end_vld) begin
            seq_d = crec_pkg::SEQ_SECOND;
          end
        end
        crec_pkg::SEQ_SECOND: begin
          seq_d = crec_pkg::SEQ_FIRST;
        end
      endcase
    end
  end

  always_comb begin
    issue     = 1'b0;
    iss       = '0;
    rec_pop_o = 1'b0;
    if (en && !rec_empty_i) begin
      issue = 1'b1;
      unique case (seq_q)
        crec_pkg::SEQ_FIRST: begin
          if (rec_i.brk_vld) begin
            iss.run    = rec_i.brk_run;
            iss.closes = 1'b0;
            iss.last   = rec_i.brk_last;
            rec_pop_o  = !rec_i.end_vld;
          end else begin
            iss.run    = rec_i.end_run;
            iss.closes = 1'b1;
            iss.last   = 1'b1;
            rec_pop_o  = 1'b1;
          end
        end
        crec_pkg::SEQ_SECOND: begin
          iss.run    = rec_i.end_run;
          iss.closes = 1'b1;
          iss.last   = 1'b1;
          rec_pop_o  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q    <= crec_pkg::SEQ_FIRST;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      seq_q <= seq_d;
      if (en) begin
        s1_vld_q <= issue;
        s2_vld_q <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pstart_q   <= crec_pkg::StartProdW'(iss.run.start)
                       * crec_pkg::StartProdW'(block_size_i);
      s1_plen_q     <= crec_pkg::LenProdW'(iss.run.count)
                       * crec_pkg::LenProdW'(block_size_i);
      s1_closes_q   <= iss.closes;
      s1_last_q     <= iss.last;
      s2_q.offset   <= base_i + crec_pkg::ExtW'(s1_pstart_q);
      s2_q.length   <= crec_pkg::ExtW'(s1_plen_q);
      s2_q.closes   <= s1_closes_q;
      s2_q.last     <= s1_last_q;
    end
  end

  assign oq_push = en && s2_vld_q;
  assign oq_pop  = pop_i && !empty_o;
  assign empty_o = (oq_cnt_q == '0);
  assign res_o   = oq_mem_q[oq_rd_q];

  always_comb begin
    oq_cnt_d = oq_cnt_q;
    if (oq_push && !oq_pop) begin
      oq_cnt_d = oq_cnt_q + CntW'(1);
    end else if (oq_pop && !oq_push) begin
      oq_cnt_d = oq_cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= '0;
      oq_rd_q  <= '0;
      oq_cnt_q <= '0;
    end else begin
      oq_cnt_q <= oq_cnt_d;
      if (oq_push) begin
        oq_wr_q <= (oq_wr_q == PtrW'(crec_pkg::OutQDepth - 1)) ? '0 : oq_wr_q + PtrW'(1);
      end
      if (oq_pop) begin
        oq_rd_q <= (oq_rd_q == PtrW'(crec_pkg::OutQDepth - 1)) ? '0 : oq_rd_q + PtrW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (oq_push) begin
      oq_mem_q[oq_wr_q] <= s2_q;
    end
  end

endmodule

// ----- rtl/cluster_run_extent_coalescer_top.sv -----
// Cluster run extent coalescer. Cluster numbers of a file's chain are pushed in chain
// order, with list_end_i set on the last one; runs of consecutive numbers are merged,
// and each finished run comes out as a byte offset and byte length, either when the
// run breaks or when the list ends. One request can be pushed every clock cycle while
// the queue between the halves has room: the front end compares each cluster with its
// predecessor combinationally, and only a request that yields two extents (a break
// together with the end of the list) occupies the back end's shared multiply pipeline
// for a second issue, so such requests lower the sustained rate. The first extent of
// a request passes the queue between the halves, the s1 and s2 registers and the
// result queue on its way out. Results wait in a four-entry queue, and up to four
// classified requests wait between the two halves, so either side may stall without
// halting the other straight away. Configuration registers are written through a
// plain write port and should be changed only while no request is in flight.
module cluster_run_extent_coalescer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Request side.
  input  logic                              push,
  output logic                              full,
  input  logic [crec_pkg::ClusterW-1:0]     cluster_i,
  input  logic                              list_end_i,
  // Result side.
  output logic                              empty,
  input  logic                              pop,
  output logic [crec_pkg::ExtW-1:0]         extent_offset_o,
  output logic [crec_pkg::ExtW-1:0]         extent_length_o,
  output logic                              closes_list_o,
  output logic                              last_in_step_o,
  // Configuration write port.
  input  logic                              cfg_we_i,
  input  logic [crec_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [crec_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [crec_pkg::BlockSizeW-1:0]  block_size_q;
  logic [crec_pkg::RootOffsetW-1:0] root_offset_q;
  logic [crec_pkg::ExtW-1:0]        base_q, base_d;

  logic                accept;
  logic                rec_vld, rec_full, rec_empty, rec_pop;
  crec_pkg::step_rec_t rec_in, rec_out;
  crec_pkg::result_t   res;

  // The configuration registers are written with no wait state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q  <= crec_pkg::BlockSizeReset;
      root_offset_q <= '0;
    end else if (cfg_we_i) begin
      unique case (crec_pkg::cfg_reg_e'(cfg_idx_i))
        crec_pkg::CFG_BLOCK_SIZE:  block_size_q  <= cfg_data_i[crec_pkg::BlockSizeW-1:0];
        crec_pkg::CFG_ROOT_OFFSET: root_offset_q <= cfg_data_i[crec_pkg::RootOffsetW-1:0];
      endcase
    end
  end

  // With a root offset the extent offset is root + (start - 2) * block size, which is
  // the same as (root - 2 * block size) + start * block size modulo 2^64. That base is
  // held in a register so the back end needs only one add after its multiplier.
  always_comb begin
    if (root_offset_q != '0) begin
      base_d = crec_pkg::ExtW'(root_offset_q) - (crec_pkg::ExtW'(block_size_q) << 1);
    end else begin
      base_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else begin
      base_q <= base_d;
    end
  end

  // A request is taken whenever the queue between the halves has room.
  assign full   = rec_full;
  assign accept = push && !rec_full;

  crec_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .acc_i      (accept),
    .cluster_i  (cluster_i[crec_pkg::ClusterBits-1:0]),
    .list_end_i (list_end_i),
    .rec_vld_o  (rec_vld),
    .rec_o      (rec_in)
  );

  crec_rec_fifo u_rec_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_vld),
    .data_i  (rec_in),
    .full_o  (rec_full),
    .pop_i   (rec_pop),
    .empty_o (rec_empty),
    .data_o  (rec_out)
  );

  crec_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_empty_i  (rec_empty),
    .rec_i        (rec_out),
    .rec_pop_o    (rec_pop),
    .block_size_i (block_size_q),
    .base_i       (base_q),
    .pop_i        (pop),
    .empty_o      (empty),
    .res_o        (res)
  );

  assign extent_offset_o = res.offset;
  assign extent_length_o = res.length;
  assign closes_list_o   = res.closes;
  assign last_in_step_o  = res.last;

endmodule

// ----- rtl/crec_checker.sv -----
module crec_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          full,
  input logic                          empty,
  input logic                          pop,
  input logic [crec_pkg::ExtW-1:0]     extent_offset_o,
  input logic [crec_pkg::ExtW-1:0]     extent_length_o,
  input logic                          closes_list_o,
  input logic                          last_in_step_o
);

  // Both queues come out of reset empty.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> (empty && !full))
    else $error("queues not empty during reset");

  // An extent that closes the list is always the last one of its request.
  a_close_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && closes_list_o) |-> last_in_step_o)
    else $error("list-closing extent not marked last");

  // A waiting result that is not taken stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(extent_offset_o) && $stable(extent_length_o)))
    else $error("waiting result changed");

endmodule

bind cluster_run_extent_coalescer_top crec_checker u_crec_checker (.*);
